// ===== src/css_pkg.sv =====
package css_pkg;

  // Action codes carried in the low bits of the input tdata
  typedef enum logic [2:0] {
    ACT_START   = 3'd0,
    ACT_ADVANCE = 3'd1,
    ACT_INSERT  = 3'd2,
    ACT_ATTACH  = 3'd3,
    ACT_REMOVE  = 3'd4,
    ACT_READ    = 3'd5
  } action_e;

  localparam int unsigned ActionWidth = 3;

  // What the row of cells does at each clock edge
  typedef enum logic [1:0] {
    ROW_HOLD  = 2'd0,
    ROW_OPEN  = 2'd1,  // load word at pos, cells above take from below
    ROW_CLOSE = 2'd2   // cells at pos and above take from above
  } row_op_e;

endpackage

// ===== src/css_cell.sv =====
module css_cell import css_pkg::*; #(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned WORD_WIDTH = 32,
  parameter int unsigned IDX        = 0,
  parameter int unsigned IDX_W      = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  row_op_e               row_op_i,
  input  logic [IDX_W-1:0]      pos_i,
  input  logic [WORD_WIDTH-1:0] word_i,
  input  logic [WORD_WIDTH-1:0] below_i,
  input  logic [WORD_WIDTH-1:0] above_i,
  output logic [WORD_WIDTH-1:0] word_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

  logic [WORD_WIDTH-1:0] word_q, word_d;
  logic                  load;

  always_comb begin
    word_d = word_q;
    load   = 1'b0;
    unique case (row_op_i)
      ROW_OPEN: begin
        if (MyIdx == pos_i) begin
          word_d = word_i;
          load   = 1'b1;
        end else if (MyIdx > pos_i) begin
          word_d = below_i;
          load   = 1'b1;
        end
      end
      ROW_CLOSE: begin
        if (MyIdx >= pos_i) begin
          word_d = above_i;
          load   = 1'b1;
        end
      end
      default: begin
        word_d = word_q;
        load   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

// ===== src/css_ctrl.sv =====
module css_ctrl import css_pkg::*; #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned IDX_W = $clog2(DEPTH),
  parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [ActionWidth-1:0] action_i,
  output row_op_e                row_op_o,
  output logic [IDX_W-1:0]       pos_o,
  output logic [IDX_W-1:0]       rd_idx_o,
  output logic                   use_word_o,
  output logic                   has_current_o,
  output logic [CNT_W-1:0]       count_o,
  output logic [CNT_W-1:0]       cursor_o,
  output logic                   err_o
);

  localparam logic [CNT_W-1:0] Full = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] One  = CNT_W'(1);

  logic [CNT_W-1:0] count_q, count_d, cursor_q, cursor_d, pos_full, cur_inc, rd_full;
  logic             valid, full, err;
  row_op_e          op;

  assign valid   = cursor_q < count_q;
  assign full    = count_q == Full;
  assign cur_inc = cursor_q + One;

  always_comb begin
    count_d  = count_q;
    cursor_d = cursor_q;
    err      = 1'b0;
    op       = ROW_HOLD;
    pos_full = cursor_q;
    rd_full  = cursor_q;
    unique case (action_i)
      ACT_START: begin
        cursor_d = '0;
        rd_full  = '0;
      end
      ACT_ADVANCE: begin
        if (!valid) begin
          err = 1'b1;
        end else begin
          cursor_d = cur_inc;
          rd_full  = cur_inc;
        end
      end
      ACT_INSERT: begin
        if (full) begin
          err = 1'b1;
        end else begin
          pos_full = valid ? cursor_q : '0;
          op       = ROW_OPEN;
          cursor_d = pos_full;
          count_d  = count_q + One;
        end
      end
      ACT_ATTACH: begin
        if (full) begin
          err = 1'b1;
        end else begin
          pos_full = valid ? cur_inc : count_q;
          op       = ROW_OPEN;
          cursor_d = pos_full;
          count_d  = count_q + One;
        end
      end
      ACT_REMOVE: begin
        if (!valid) begin
          err = 1'b1;
        end else begin
          op      = ROW_CLOSE;
          count_d = count_q - One;
          rd_full = cur_inc;
        end
      end
      default: begin
        err = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cursor_q <= '0;
    end else if (accept_i) begin
      count_q  <= count_d;
      cursor_q <= cursor_d;
    end
  end

  // Position is below DEPTH whenever the row is told to move
  assign row_op_o      = accept_i ? op : ROW_HOLD;
  assign pos_o         = pos_full[IDX_W-1:0];
  assign rd_idx_o      = rd_full[IDX_W-1:0];
  assign use_word_o    = op == ROW_OPEN;
  assign has_current_o = cursor_d < count_d;
  assign count_o       = count_d;
  assign cursor_o      = cursor_d;
  assign err_o         = err;

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= count_q)
    else $error("cursor beyond count");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("count beyond depth");

  a_refused_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && err |=> count_q == $past(count_q) && cursor_q == $past(cursor_q))
    else $error("refused action changed state");

  a_row_idle_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err |-> row_op_o == ROW_HOLD)
    else $error("row moved on a refused action");

endmodule

// ===== src/cursor_sequence_store_core.sv =====
// Ordered list of up to DEPTH words with a cursor, held in a row of register
// cells. Each input transaction carries an action (start, advance, insert
// before, attach after, remove, read) and a word; every transaction returns
// exactly one result: the word under the cursor after the action, whether
// there is one, the count, the cursor and an error flag for a refused action
// (full list, or no current entry for advance/remove). Insert and attach shift
// all later cells up and remove shifts them down in the same clock, so a new
// transaction is taken every cycle that the result register is free or being
// drained. The result is returned from the output register. Cell contents
// are not reset; only entries below the count are ever read.
module cursor_sequence_store_core import css_pkg::*; #(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // action, entry_value (low bit first)
  input  logic [((ActionWidth + WORD_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // current_value, has_current, item_count, cursor_position, op_error
  output logic [((WORD_WIDTH + 2 + 2 * $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

  logic                   accept;
  logic [ActionWidth-1:0] action;
  logic [WORD_WIDTH-1:0]  in_word;
  row_op_e                row_op;
  logic [IDX_W-1:0]       pos, rd_idx;
  logic                   use_word, has_current, err;
  logic [CNT_W-1:0]       count, cursor;
  logic [WORD_WIDTH-1:0]  cell_word [DEPTH];
  logic [WORD_WIDTH-1:0]  cur_word;

  logic                   out_valid_q;
  logic [WORD_WIDTH-1:0]  out_word_q;
  logic                   out_has_q, out_err_q;
  logic [CNT_W-1:0]       out_count_q, out_cursor_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign action        = s_axis_tdata[ActionWidth-1:0];
  assign in_word       = s_axis_tdata[ActionWidth +: WORD_WIDTH];

  css_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .action_i      (action),
    .row_op_o      (row_op),
    .pos_o         (pos),
    .rd_idx_o      (rd_idx),
    .use_word_o    (use_word),
    .has_current_o (has_current),
    .count_o       (count),
    .cursor_o      (cursor),
    .err_o         (err)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] below, above;
    if (i == 0) begin : g_first
      assign below = '0;
    end else begin : g_mid
      assign below = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign above = cell_word[i];
    end else begin : g_inner
      assign above = cell_word[i+1];
    end
    css_cell #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk_i    (clk_i),
      .row_op_i (row_op),
      .pos_i    (pos),
      .word_i   (in_word),
      .below_i  (below),
      .above_i  (above),
      .word_o   (cell_word[i])
    );
  end

  // Word under the new cursor, taken from the row before it moves
  always_comb begin
    if (!has_current) begin
      cur_word = '0;
    end else if (use_word) begin
      cur_word = in_word;
    end else begin
      cur_word = cell_word[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_word_q   <= cur_word;
      out_has_q    <= has_current;
      out_count_q  <= count;
      out_cursor_q <= cursor;
      out_err_q    <= err;
    end
  end

  assign m_axis_tvalid = out_valid_q;

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[WORD_WIDTH-1:0]                 = out_word_q;
    m_axis_tdata[WORD_WIDTH]                     = out_has_q;
    m_axis_tdata[WORD_WIDTH+1 +: CNT_W]          = out_count_q;
    m_axis_tdata[WORD_WIDTH+1+CNT_W +: CNT_W]    = out_cursor_q;
    m_axis_tdata[WORD_WIDTH+1+2*CNT_W]           = out_err_q;
  end

endmodule
